>>> src/csr_sparse_row_dot_product_core_macros.svh
// assertion macros shared by the checker
`ifndef CSR_SPARSE_ROW_DOT_PRODUCT_CORE_MACROS_SVH
`define CSR_SPARSE_ROW_DOT_PRODUCT_CORE_MACROS_SVH

// property checked only while out of reset
`define CSR_SPMV_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// property checked at every edge, reset included
`define CSR_SPMV_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

>>> src/csr_spmv_pkg.sv
`default_nettype none
package csr_spmv_pkg;

  // vector store geometry and row counter width
  localparam int VECTOR_DEPTH = 4096;
  localparam int ADDR_W       = $clog2(VECTOR_DEPTH);
  localparam int ROW_BITS     = 20;

  // fixed field widths
  localparam int IDX_W     = 20;
  localparam int VAL_W     = 32;
  localparam int SUM_W     = 64;
  localparam int OUT_ROW_W = 20;

  // decoupling queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_NONZERO = 2'd1,
    OP_EMPTY   = 2'd2,
    OP_RESTART = 2'd3
  } op_e;

  // one classified word on its way from front to back
  typedef struct packed {
    op_e                     op;
    logic                    last;
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] value;
    logic signed [VAL_W-1:0] x;
  } entry_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage
`default_nettype wire

>>> src/csr_spmv_ram.sv
`default_nettype none
module csr_spmv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

>>> src/csr_spmv_front.sv
`default_nettype none
module csr_spmv_front
  import csr_spmv_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [1:0]              operation_i,
  input  wire logic [IDX_W-1:0]        index_i,
  input  wire logic signed [VAL_W-1:0] value_i,
  input  wire logic                    last_in_row_i,
  input  wire logic                    fifo_full_i,
  output logic                         push_o,
  output entry_t                       push_entry_o
);

  op_e               op;
  logic              accept;
  logic              in_range;
  logic [VAL_W-1:0]  rdata;

  logic              s1_valid_q, s1_valid_d;
  op_e               s1_op_q;
  logic              s1_last_q;
  logic [IDX_W-1:0]  s1_index_q;
  logic [VAL_W-1:0]  s1_value_q;
  logic              s1_in_range_q;

  assign op       = op_e'(operation_i);
  assign in_range = ({1'b0, index_i} < (IDX_W+1)'(VECTOR_DEPTH));
  assign push_o   = s1_valid_q && !fifo_full_i;
  // stage one may refill in the cycle it drains
  assign in_ready_o = !s1_valid_q || !fifo_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // loads write at acceptance, nonzeros read at acceptance: order is kept
  csr_spmv_ram #(
    .WIDTH(VAL_W),
    .DEPTH(VECTOR_DEPTH)
  ) u_vec_ram (
    .clk_i  (clk_i),
    .we_i   (accept && (op == OP_LOAD) && in_range),
    .waddr_i(index_i[ADDR_W-1:0]),
    .wdata_i(value_i),
    .re_i   (accept && (op == OP_NONZERO) && in_range),
    .raddr_i(index_i[ADDR_W-1:0]),
    .rdata_o(rdata)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = (op != OP_LOAD);
    end else if (push_o) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q       <= op;
      s1_last_q     <= last_in_row_i;
      s1_index_q    <= index_i;
      s1_value_q    <= value_i;
      s1_in_range_q <= in_range;
    end
  end

  always_comb begin
    push_entry_o.op    = s1_op_q;
    push_entry_o.last  = s1_last_q;
    push_entry_o.index = s1_index_q;
    push_entry_o.value = s1_value_q;
    // out-of-range column contributes nothing
    push_entry_o.x     = s1_in_range_q ? rdata : '0;
  end

endmodule
`default_nettype wire

>>> src/csr_spmv_fifo.sv
`default_nettype none
module csr_spmv_fifo
  import csr_spmv_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire entry_t push_entry_i,
  input  wire logic   pop_i,
  output entry_t      head_o,
  output fifo_status_t status_o
);

  entry_t                slot_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wptr_q, wptr_d;
  logic [FIFO_PTR_W-1:0] rptr_q, rptr_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;

  assign status_o.full  = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign head_o         = slot_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wptr_q + FIFO_PTR_W'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rptr_q + FIFO_PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + FIFO_CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= push_entry_i;
    end
  end

endmodule
`default_nettype wire

>>> src/csr_spmv_back.sv
`default_nettype none
module csr_spmv_back
  import csr_spmv_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire entry_t                  head_i,
  input  wire logic                    fifo_empty_i,
  output logic                         pop_o,
  input  wire logic                    out_ready_i,
  output logic                         out_valid_o,
  output logic [OUT_ROW_W-1:0]         row_number_o,
  output logic signed [SUM_W-1:0]      row_sum_o,
  output logic                         saturated_o
);

  // multiply stage
  logic                    a_valid_q, a_valid_d;
  op_e                     a_op_q;
  logic                    a_last_q;
  logic [IDX_W-1:0]        a_index_q;
  logic signed [SUM_W-1:0] a_prod_q;
  logic signed [SUM_W-1:0] prod;

  // row state
  logic signed [SUM_W-1:0] acc_q, acc_d;
  logic                    clip_q, clip_d;
  logic [ROW_BITS-1:0]     row_q, row_d;

  // result register
  logic                    out_valid_q, out_valid_d;
  logic [OUT_ROW_W-1:0]    out_row_q;
  logic signed [SUM_W-1:0] out_sum_q;
  logic                    out_sat_q;

  logic                    out_free;
  logic                    adv;
  logic signed [SUM_W-1:0] sum;
  logic                    ovf;
  logic signed [SUM_W-1:0] sum_sat;
  logic                    emit;
  logic signed [SUM_W-1:0] emit_sum;
  logic                    emit_sat;

  // exact 32x32 signed product in 64-bit context
  assign prod = head_i.value * head_i.x;

  always_comb begin
    out_free = !out_valid_q || out_ready_i;
    adv      = a_valid_q && out_free;
    pop_o    = !fifo_empty_i && (!a_valid_q || adv);

    sum     = acc_q + a_prod_q;
    ovf     = (acc_q[SUM_W-1] == a_prod_q[SUM_W-1]) && (sum[SUM_W-1] != acc_q[SUM_W-1]);
    sum_sat = ovf ? (acc_q[SUM_W-1] ? SUM_MIN : SUM_MAX) : sum;

    acc_d    = acc_q;
    clip_d   = clip_q;
    row_d    = row_q;
    emit     = 1'b0;
    emit_sum = '0;
    emit_sat = 1'b0;

    if (adv) begin
      unique case (a_op_q)
        OP_NONZERO: begin
          if (a_last_q) begin
            emit     = 1'b1;
            emit_sum = sum_sat;
            emit_sat = clip_q || ovf;
            acc_d    = '0;
            clip_d   = 1'b0;
            row_d    = row_q + ROW_BITS'(1);
          end else begin
            acc_d  = sum_sat;
            clip_d = clip_q || ovf;
          end
        end
        OP_EMPTY: begin
          emit   = 1'b1;
          acc_d  = '0;
          clip_d = 1'b0;
          row_d  = row_q + ROW_BITS'(1);
        end
        OP_RESTART: begin
          acc_d  = '0;
          clip_d = 1'b0;
          row_d  = ROW_BITS'(a_index_q);
        end
        OP_LOAD: begin
          // loads never enter the queue
        end
      endcase
    end

    a_valid_d = pop_o ? 1'b1 : (adv ? 1'b0 : a_valid_q);
    out_valid_d = emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      acc_q       <= '0;
      clip_q      <= 1'b0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      a_valid_q   <= a_valid_d;
      acc_q       <= acc_d;
      clip_q      <= clip_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      a_op_q    <= head_i.op;
      a_last_q  <= head_i.last;
      a_index_q <= head_i.index;
      a_prod_q  <= prod;
    end
    if (emit) begin
      out_row_q <= OUT_ROW_W'(row_q);
      out_sum_q <= emit_sum;
      out_sat_q <= emit_sat;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign row_number_o = out_row_q;
  assign row_sum_o    = out_sum_q;
  assign saturated_o  = out_sat_q;

endmodule
`default_nettype wire

>>> src/csr_sparse_row_dot_product_core.sv
// channel   | handshake               | payload
// ----------+-------------------------+-------------------------------------------
// input     | in_valid_i / in_ready_o | operation_i index_i value_i last_in_row_i
// output    | out_valid_o/out_ready_i | row_number_o row_sum_o saturated_o
//
// one word per cycle sustained while results are taken; a result word is registered
// after the vector store read, the queue, the multiply register and the accumulate
// rate is set by the saturating 64-bit accumulate loop in the back end
// reset clears control state, row counter and accumulator; vector store is not cleared
// a stalled output holds the back end only; the front keeps taking words until the
// four-entry queue is full and stage one holds a word
`default_nettype none
module csr_sparse_row_dot_product_core
  import csr_spmv_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // input words
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [1:0]              operation_i,
  input  wire logic [IDX_W-1:0]        index_i,
  input  wire logic signed [VAL_W-1:0] value_i,
  input  wire logic                    last_in_row_i,
  // result words
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [OUT_ROW_W-1:0]         row_number_o,
  output logic signed [SUM_W-1:0]      row_sum_o,
  output logic                         saturated_o
);

  // front to queue
  logic         push;
  entry_t       push_entry;
  // queue to back
  logic         pop;
  entry_t       head;
  fifo_status_t fifo_status;

  // front: classifies words, owns the vector store; loads end here
  csr_spmv_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .index_i      (index_i),
    .value_i      (value_i),
    .last_in_row_i(last_in_row_i),
    .fifo_full_i  (fifo_status.full),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  // queue: nonzero, empty-row and restart words with their vector operand
  csr_spmv_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_entry_i(push_entry),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (fifo_status)
  );

  // back: multiply, saturating accumulate, row bookkeeping, result register
  csr_spmv_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .fifo_empty_i (fifo_status.empty),
    .pop_o        (pop),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .row_number_o (row_number_o),
    .row_sum_o    (row_sum_o),
    .saturated_o  (saturated_o)
  );

endmodule
`default_nettype wire

>>> src/csr_spmv_checker.sv
`default_nettype none
`include "csr_sparse_row_dot_product_core_macros.svh"
module csr_spmv_checker
  import csr_spmv_pkg::*;
(
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    out_valid_o,
  input wire logic                    out_ready_i,
  input wire logic [OUT_ROW_W-1:0]    row_number_o,
  input wire logic signed [SUM_W-1:0] row_sum_o,
  input wire logic                    saturated_o
);

  // a stalled result word stays offered
  `CSR_SPMV_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o)

  // a stalled result word keeps its payload
  `CSR_SPMV_ASSERT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i |=> $stable(row_number_o) && $stable(row_sum_o) && $stable(saturated_o))

  // nothing is offered as reset lifts
  `CSR_SPMV_ASSERT_ALWAYS(a_reset_clean, clk_i, $rose(rst_ni) |-> !out_valid_o)

  // a result needs a word through the whole pipeline since reset
  `CSR_SPMV_ASSERT(a_min_latency, clk_i, rst_ni, $rose(out_valid_o) |-> $past(rst_ni, 3))

endmodule

bind csr_sparse_row_dot_product_core csr_spmv_checker u_checker (.*);
`default_nettype wire

>>> tb/csr_sparse_row_dot_product_core_tb.sv
`default_nettype none
module csr_sparse_row_dot_product_core_tb;
  import csr_spmv_pkg::*;

  // quiet cycles on both channels before the run is declared hung
  localparam int STALL_LIMIT   = 4000;
  // cycles left after the last result so a late stray word still shows up
  localparam int SETTLE_CYCLES = 12;
  // long output hold-off used to fill the internal queue
  localparam int HOLD_OFF_LEN  = 300;
  // cap on printed error lines, counting goes on past it
  localparam int PRINT_CAP     = 40;

  // clock, reset and block ports; the inputs are known from time zero
  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    in_valid_i    = 1'b0;
  logic                    in_ready_o;
  logic [1:0]              operation_i   = OP_LOAD;
  logic [IDX_W-1:0]        index_i       = '0;
  logic signed [VAL_W-1:0] value_i       = '0;
  logic                    last_in_row_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_ready_i   = 1'b0;
  logic [OUT_ROW_W-1:0]    row_number_o;
  logic signed [SUM_W-1:0] row_sum_o;
  logic                    saturated_o;

  csr_sparse_row_dot_product_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .index_i       (index_i),
    .value_i       (value_i),
    .last_in_row_i (last_in_row_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .row_number_o  (row_number_o),
    .row_sum_o     (row_sum_o),
    .saturated_o   (saturated_o)
  );

  // one finished row as the block should report it
  typedef struct packed {
    logic [OUT_ROW_W-1:0]    row;
    logic signed [SUM_W-1:0] sum;
    logic                    sat;
  } row_result_t;

  // rows whose result word is still due, oldest first
  row_result_t pending_rows[$];

  // shadow of the block state
  logic signed [VAL_W-1:0] vec_mem [VECTOR_DEPTH];
  bit                      vec_written [VECTOR_DEPTH];
  int unsigned             loaded_cols[$];   // vector entries that are safe to read
  logic signed [SUM_W-1:0] acc_q  = '0;
  logic                    clip_q = 1'b0;
  logic [ROW_BITS-1:0]     row_q  = '0;

  // traffic shaping, percent per cycle
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_off_left  = 0;
  int mismatches     = 0;

  initial begin : clock_gen
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // error reporting
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [SUM_W-1:0] want_v,
                                 logic [SUM_W-1:0] got_v);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("error: %s: expected %h, got %h", what, want_v, got_v);
  endtask

  // ---------------------------------------------------------------------------
  // row sum prediction
  // ---------------------------------------------------------------------------

  // close the current row: queue its result, clear the sum, step the row counter
  function automatic void finish_row(logic signed [SUM_W-1:0] sum, logic sat);
    row_result_t r;
    r.row = row_q[OUT_ROW_W-1:0];
    r.sum = sum;
    r.sat = sat;
    pending_rows.push_back(r);
    row_q  = row_q + 1'b1;
    acc_q  = '0;
    clip_q = 1'b0;
  endfunction

  // apply one accepted word to the shadow state
  function automatic void predict_word(op_e op, logic [IDX_W-1:0] idx,
                                       logic signed [VAL_W-1:0] val, logic last);
    logic signed [SUM_W-1:0] vx;
    logic signed [SUM_W-1:0] vm;
    logic signed [SUM_W-1:0] prod;
    logic signed [SUM_W-1:0] s;
    vx = '0;
    vm = val;
    case (op)
      OP_LOAD: begin
        // loads past the store are dropped
        if (idx < VECTOR_DEPTH) begin
          if (!vec_written[idx]) begin
            vec_written[idx] = 1'b1;
            loaded_cols.push_back(idx);
          end
          vec_mem[idx] = val;
        end
      end
      OP_NONZERO: begin
        // a column past the store multiplies by zero
        if (idx < VECTOR_DEPTH)
          vx = vec_mem[idx];
        prod = vm * vx;
        s = acc_q + prod;
        // overflow only when both addends agree in sign and the sum does not
        if (acc_q[SUM_W-1] == prod[SUM_W-1] && s[SUM_W-1] != acc_q[SUM_W-1]) begin
          s = acc_q[SUM_W-1] ? SUM_MIN : SUM_MAX;
          clip_q = 1'b1;
        end
        acc_q = s;
        if (last)
          finish_row(acc_q, clip_q);
      end
      OP_EMPTY: begin
        // any partial sum is thrown away
        finish_row('0, 1'b0);
      end
      default: begin
        // restart: new row number, partial sum dropped, no result
        row_q  = idx[ROW_BITS-1:0];
        acc_q  = '0;
        clip_q = 1'b0;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // offer one word after a random idle gap and hold it until taken
  task automatic send_word(op_e op, logic [IDX_W-1:0] idx,
                           logic signed [VAL_W-1:0] val, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    index_i       <= idx;
    value_i       <= val;
    last_in_row_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_word(op, idx, val, last);
  endtask

  // stop offering words until every predicted row has come out
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // operand mix: extremes, 2^16, zero, full random and scaled-down random
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return 32'sh0001_0000;
      4, 5: return $urandom;
      default: return $signed(32'($urandom)) >>> $urandom_range(24);
    endcase
  endfunction

  // mostly inside the store, sometimes anywhere in the index range
  function automatic logic [IDX_W-1:0] pick_load_index();
    if ($urandom_range(99) < 85)
      return IDX_W'($urandom_range(VECTOR_DEPTH - 1));
    return IDX_W'($urandom);
  endfunction

  // a loaded column, or now and then one past the store
  function automatic logic [IDX_W-1:0] pick_column();
    if ($urandom_range(9) == 0)
      return IDX_W'(VECTOR_DEPTH + $urandom_range((1 << IDX_W) - 1 - VECTOR_DEPTH));
    return IDX_W'(loaded_cols[$urandom_range(loaded_cols.size() - 1)]);
  endfunction

  // ---------------------------------------------------------------------------
  // output side
  // ---------------------------------------------------------------------------

  // ready with random stalls, or held low for a counted stretch
  initial begin : result_sink
    forever begin
      @(posedge clk_i);
      if (hold_off_left > 0) begin
        hold_off_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // compare each taken result word with the oldest predicted row
  initial begin : result_check
    row_result_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (pending_rows.size() == 0) begin
          report_mismatch("result word with no row due", '0, row_sum_o);
        end else begin
          want = pending_rows.pop_front();
          if (row_number_o !== want.row)
            report_mismatch("row_number", want.row, row_number_o);
          if (row_sum_o !== want.sum)
            report_mismatch("row_sum", want.sum, row_sum_o);
          if (saturated_o !== want.sat)
            report_mismatch("saturated", want.sat, saturated_o);
        end
      end
    end
  end

  // hang detection: no word moved on either channel for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        quiet = 0;
      else
        quiet++;
    end
    $display("csr_sparse_row_dot_product_core: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // corner cases: extremes, clipping both ways, out-of-range columns,
  // rows cut short by an empty row or a restart, and row number wrap
  task automatic test_directed_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_word(OP_LOAD, 20'd0,    32'sh7fff_ffff, 1'b0);
    send_word(OP_LOAD, 20'd1,    32'sh8000_0000, 1'b1);
    send_word(OP_LOAD, 20'd2,    32'shffff_ffff, 1'b0);
    send_word(OP_LOAD, 20'd4095, 32'sh0001_0000, 1'b0);
    // loads past the store must leave it alone
    send_word(OP_LOAD, 20'hfffff, 32'sh1234_5678, 1'b0);
    send_word(OP_LOAD, 20'd4096,  32'sh5555_aaaa, 1'b1);
    // largest positive square in one row
    send_word(OP_NONZERO, 20'd0, 32'sh7fff_ffff, 1'b1);
    // 2^62 three times clips to the top and stays clipped
    send_word(OP_NONZERO, 20'd1, 32'sh8000_0000, 1'b0);
    send_word(OP_NONZERO, 20'd1, 32'sh8000_0000, 1'b0);
    send_word(OP_NONZERO, 20'd1, 32'sh8000_0000, 1'b1);
    // large negative products clip to the bottom
    send_word(OP_NONZERO, 20'd1, 32'sh7fff_ffff, 1'b0);
    send_word(OP_NONZERO, 20'd1, 32'sh7fff_ffff, 1'b0);
    send_word(OP_NONZERO, 20'd1, 32'sh7fff_ffff, 1'b1);
    // column past the store adds nothing but still ends the row
    send_word(OP_NONZERO, 20'hfffff, 32'sh1234_5678, 1'b1);
    // empty row drops a partial sum
    send_word(OP_NONZERO, 20'd4095, 32'sh7fff_0000, 1'b0);
    send_word(OP_EMPTY, 20'habcde, 32'sh7654_3210, 1'b1);
    // restart drops a partial sum and moves near the top of the row range
    send_word(OP_NONZERO, 20'd2, 32'sh8000_0000, 1'b0);
    send_word(OP_RESTART, 20'hffffe, 32'shffff_ffff, 1'b1);
    send_word(OP_NONZERO, 20'd4095, 32'sh0001_0000, 1'b1);
    // row number wraps past the top
    send_word(OP_EMPTY, 20'h0, 32'sh0, 1'b0);
    send_word(OP_EMPTY, 20'hfffff, 32'shffff_ffff, 1'b0);
    send_word(OP_RESTART, 20'h0, 32'sh0, 1'b0);
    send_word(OP_NONZERO, 20'd2, 32'shffff_ffff, 1'b1);
    wait_for_results();
  endtask

  // hold the output off while words keep coming, so the queue fills and
  // the input stalls; then drain completely before going on
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_left  = HOLD_OFF_LEN;
    for (int k = 0; k < 40; k++) begin
      if (k % 3 == 2)
        send_word(OP_EMPTY, IDX_W'($urandom), $urandom, 1'($urandom));
      else
        send_word(OP_NONZERO, pick_column(), pick_value(), 1'b1);
    end
    wait_for_results();
  endtask

  // mostly well-formed rows with random content, some vector loads,
  // and noise: empty rows, restarts and rows cut short
  task automatic test_random_traffic(int send_pct, int recv_pct, int n_words);
    int sent;
    int kind;
    int len;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    sent = 0;
    while (sent < n_words) begin
      kind = $urandom_range(99);
      if (kind < 12) begin
        len = $urandom_range(1, 4);
        repeat (len) begin
          send_word(OP_LOAD, pick_load_index(), pick_value(), 1'($urandom));
          sent++;
        end
      end else if (kind < 78) begin
        len = ($urandom_range(3) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 4);
        for (int k = 0; k < len; k++) begin
          send_word(OP_NONZERO, pick_column(), pick_value(), k == len - 1);
          sent++;
        end
      end else if (kind < 84) begin
        // row that never sees its last mark
        len = $urandom_range(1, 4);
        repeat (len) begin
          send_word(OP_NONZERO, pick_column(), pick_value(), 1'b0);
          sent++;
        end
        if ($urandom_range(1) == 0)
          send_word(OP_EMPTY, IDX_W'($urandom), $urandom, 1'($urandom));
        else
          send_word(OP_RESTART, IDX_W'($urandom), $urandom, 1'($urandom));
        sent++;
      end else if (kind < 92) begin
        send_word(OP_EMPTY, IDX_W'($urandom), $urandom, 1'($urandom));
        sent++;
      end else begin
        send_word(OP_RESTART, IDX_W'($urandom), $urandom, 1'($urandom));
        sent++;
      end
    end
    wait_for_results();
  endtask

  initial begin : main
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_backpressure();
    test_random_traffic(0, 0, 420);
    test_random_traffic(55, 0, 420);
    test_random_traffic(0, 55, 420);
    test_random_traffic(30, 30, 420);
    if (pending_rows.size() != 0)
      report_mismatch("rows never reported", pending_rows.size(), '0);
    if (mismatches == 0)
      $display("csr_sparse_row_dot_product_core: match");
    else
      $display("csr_sparse_row_dot_product_core: mismatch");
    $finish;
  end

endmodule
`default_nettype wire
